/* sv/pps_pkg.sv */
// Shared widths and controller to datapath command and status types for the scheduler.
package pps_pkg;

  localparam int ARR_W  = 12;
  localparam int BUR_W  = 12;
  localparam int PRI_W  = 8;
  localparam int TIDX_W = 4;
  localparam int TIME_W = 17;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_rd;
    logic tick_upd;
    logic out_rd;
    logic out_load;
    logic out_next;
    logic run_end;
  } cmd_t;

  typedef struct packed {
    logic all_zero;
    logic scan_last;
    logic run_done;
    logic out_last;
  } sts_t;

endpackage

/* sv/pps_ctrl.sv */
// Controller state machine that sequences loading, tick scans, updates and result output.
module pps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_acc,
  input  logic          in_last,
  input  logic          out_acc,
  input  pps_pkg::sts_t sts,
  output pps_pkg::cmd_t cmd,
  output logic          in_stall
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OCAP  = 3'd6;
  localparam logic [2:0] S_OHOLD = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.load = in_acc;
        if (in_acc && in_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = sts.all_zero ? S_ORD : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.tick_upd = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = sts.run_done ? S_ORD : S_SCAN;
      end
      S_ORD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OCAP;
      end
      S_OCAP: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_acc) begin
          if (sts.out_last) begin
            cmd.run_end = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            cmd.out_next = 1'b1;
            state_nxt    = S_ORD;
          end
        end
      end
    endcase
  end

  assign in_stall = (state_r != S_LOAD);

endmodule

/* sv/pps_dp.sv */
// Datapath with the task stores, tick counter, priority scan and result registers.
module pps_dp #(
  parameter int MAX_TASKS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pps_pkg::cmd_t               cmd,
  output pps_pkg::sts_t               sts,
  input  logic [pps_pkg::ARR_W-1:0]   in_arrival_time,
  input  logic [pps_pkg::BUR_W-1:0]   in_burst_length,
  input  logic [pps_pkg::PRI_W-1:0]   in_task_priority,
  input  logic                        out_acc,
  output logic                        out_valid,
  output logic [pps_pkg::TIDX_W-1:0]  out_task_index,
  output logic [pps_pkg::TIME_W-1:0]  out_turnaround,
  output logic [pps_pkg::TIME_W-1:0]  out_waiting,
  output logic                        out_last_result
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int AW    = pps_pkg::ARR_W;
  localparam int BW    = pps_pkg::BUR_W;
  localparam int PW    = pps_pkg::PRI_W;
  localparam int TW    = pps_pkg::TIME_W;

  logic [AW-1:0] arrival_mem    [MAX_TASKS];
  logic [BW-1:0] burst_mem      [MAX_TASKS];
  logic [PW-1:0] priority_mem   [MAX_TASKS];
  logic [BW-1:0] remaining_mem  [MAX_TASKS];
  logic [TW-1:0] turnaround_mem [MAX_TASKS];

  logic [CNT_W-1:0] loaded_r;
  logic [CNT_W-1:0] finished_r;
  logic [TW-1:0]    tick_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             found_r;
  logic [PW-1:0]    best_pri_r;
  logic [IDX_W-1:0] pick_r;
  logic [BW-1:0]    pick_rem_r;
  logic [AW-1:0]    pick_arr_r;
  logic [AW-1:0]    arr_rd_r;
  logic [PW-1:0]    pri_rd_r;
  logic [BW-1:0]    rem_rd_r;
  logic [TW-1:0]    tat_rd_r;
  logic [BW-1:0]    bur_rd_r;
  logic             out_valid_r;
  logic [pps_pkg::TIDX_W-1:0] out_tidx_r;
  logic [TW-1:0]    out_tat_r;
  logic [TW-1:0]    out_wait_r;
  logic             out_last_r;

  logic             store_ok;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] loaded_m1;
  logic [TW-1:0]    tick_inc;
  logic [TW-1:0]    fin_tat;
  logic             finish_now;
  logic [CNT_W-1:0] finished_upd;
  logic             task_ready;
  logic             take_task;
  logic [IDX_W+pps_pkg::TIDX_W-1:0] tidx_ext;

  assign store_ok     = (loaded_r < CNT_W'(MAX_TASKS));
  assign wr_idx       = loaded_r[IDX_W-1:0];
  assign loaded_m1    = loaded_r - CNT_W'(1);
  assign tick_inc     = tick_r + TW'(1);
  assign fin_tat      = tick_inc - TW'(pick_arr_r);
  assign finish_now   = found_r && (pick_rem_r == BW'(1));
  assign finished_upd = finished_r + CNT_W'(finish_now);
  assign task_ready   = (TW'(arr_rd_r) <= tick_r) && (rem_rd_r != '0);
  assign take_task    = cmp_vld_r && task_ready && (!found_r || (pri_rd_r < best_pri_r));
  assign tidx_ext     = {{pps_pkg::TIDX_W{1'b0}}, out_idx_r};

  assign sts.all_zero  = (finished_r == loaded_r);
  assign sts.scan_last = (scan_idx_r == loaded_m1[IDX_W-1:0]);
  assign sts.run_done  = (finished_upd == loaded_r);
  assign sts.out_last  = (out_idx_r == loaded_m1[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      arrival_mem[wr_idx]  <= in_arrival_time;
      priority_mem[wr_idx] <= in_task_priority;
    end
    if (cmd.scan_rd) begin
      arr_rd_r <= arrival_mem[scan_idx_r];
      pri_rd_r <= priority_mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      burst_mem[wr_idx] <= in_burst_length;
    end
    if (cmd.out_rd) begin
      bur_rd_r <= burst_mem[out_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      remaining_mem[wr_idx] <= in_burst_length;
    end else if (cmd.tick_upd && found_r) begin
      remaining_mem[pick_r] <= pick_rem_r - BW'(1);
    end
    if (cmd.scan_rd) begin
      rem_rd_r <= remaining_mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      turnaround_mem[wr_idx] <= '0;
    end else if (cmd.tick_upd && finish_now) begin
      turnaround_mem[pick_r] <= fin_tat;
    end
    if (cmd.out_rd) begin
      tat_rd_r <= turnaround_mem[out_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      finished_r  <= '0;
      tick_r      <= '0;
      scan_idx_r  <= '0;
      out_idx_r   <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_rd;
      if (cmd.run_end) begin
        loaded_r   <= '0;
        finished_r <= '0;
        tick_r     <= '0;
        out_idx_r  <= '0;
      end else if (cmd.load && store_ok) begin
        loaded_r   <= loaded_r + CNT_W'(1);
        finished_r <= finished_r + CNT_W'(in_burst_length == '0);
      end else if (cmd.tick_upd) begin
        tick_r     <= tick_inc;
        finished_r <= finished_upd;
      end else if (cmd.out_next) begin
        out_idx_r <= out_idx_r + IDX_W'(1);
      end
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
        if (take_task) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
    if (take_task) begin
      best_pri_r <= pri_rd_r;
      pick_r     <= cmp_idx_r;
      pick_rem_r <= rem_rd_r;
      pick_arr_r <= arr_rd_r;
    end
    if (cmd.out_load) begin
      out_tidx_r <= tidx_ext[pps_pkg::TIDX_W-1:0];
      out_tat_r  <= tat_rd_r;
      out_wait_r <= (bur_rd_r == '0) ? '0 : (tat_rd_r - TW'(bur_rd_r));
      out_last_r <= sts.out_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_task_index  = out_tidx_r;
  assign out_turnaround  = out_tat_r;
  assign out_waiting     = out_wait_r;
  assign out_last_result = out_last_r;

endmodule

/* sv/priority_preemptive_scheduler_unit.sv */
// Top level of the preemptive priority scheduler: controller and datapath.
// Usage:
// Task descriptors enter on the in_ channel, one word per task, in load order.
// A word is taken at a clock edge where in_valid is high and in_stall is low.
// Up to MAX_TASKS words are stored; further words of the same set are dropped.
// The word with in_last_task set starts the schedule from tick zero.
// While the schedule runs and results drain, in_stall stays high.
// Each simulated tick reads the task stores once for each of the N stored
// tasks, then passes through one compare state and one update state; a run
// begins with one start state.
// Results leave on the out_ channel, one word per task in load order, with
// out_last_result on the final word; each word is read, captured, then held.
// A word is taken when out_valid is high and out_stall is low; while the
// receiver stalls, the word holds and the block waits.
// After the final result the block takes a new set at the next cycle.
// Reset (rst_n low, synchronous) empties the store and returns to loading.
module priority_preemptive_scheduler_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pps_pkg::ARR_W-1:0]   in_arrival_time,
  input  logic [pps_pkg::BUR_W-1:0]   in_burst_length,
  input  logic [pps_pkg::PRI_W-1:0]   in_task_priority,
  input  logic                        in_last_task,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pps_pkg::TIDX_W-1:0]  out_task_index,
  output logic [pps_pkg::TIME_W-1:0]  out_turnaround,
  output logic [pps_pkg::TIME_W-1:0]  out_waiting,
  output logic                        out_last_result
);

  pps_pkg::cmd_t cmd;
  pps_pkg::sts_t sts;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_last  (in_last_task),
    .out_acc  (out_acc),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  pps_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_arrival_time  (in_arrival_time),
    .in_burst_length  (in_burst_length),
    .in_task_priority (in_task_priority),
    .out_acc          (out_acc),
    .out_valid        (out_valid),
    .out_task_index   (out_task_index),
    .out_turnaround   (out_turnaround),
    .out_waiting      (out_waiting),
    .out_last_result  (out_last_result)
  );

endmodule
